// ----- hw/rtl/rmj_pkg.sv -----
// Shared types, widths and the output saturation helper for the radar
// measurement Jacobian. No dependencies.
package rmj_pkg;

    localparam int QW = 33;

    // Payload that rides alongside the square root chain.
    typedef struct packed {
        logic [63:0] sq;
        logic [31:0] mx;
        logic [31:0] my;
        logic [63:0] cmag;
        logic        nx;
        logic        ny;
        logic        cneg;
        logic        flag;
    } sqrt_tag_t;

    // Signs and floor flag that ride alongside the divider chain.
    typedef struct packed {
        logic nx;
        logic ny;
        logic cneg;
        logic flag;
    } side_t;

    // Apply sign to a clamped magnitude and saturate to 32 bits.
    function automatic logic [31:0] sat_q(logic [QW-1:0] q, logic neg);
        logic [QW-1:0] mag;
        logic [QW-1:0] mneg;
        begin
            if (neg)
            begin
                mag  = (q > 33'h080000000) ? 33'h080000000 : q;
                mneg = 33'd0 - mag;
                sat_q = mneg[31:0];
            end
            else
            begin
                mag  = (q > 33'h07FFFFFFF) ? 33'h07FFFFFFF : q;
                mneg = mag;
                sat_q = mneg[31:0];
            end
        end
    endfunction

endpackage

// ----- hw/rtl/rmj_sqrt_cell.sv -----
// One bit step of the integer square root chain.
// Depends on nothing but its inputs.
module rmj_sqrt_cell #(
    parameter int K = 0
) (
    input  logic        clk,
    input  logic [63:0] v_in,
    input  logic [63:0] res_in,
    output logic [63:0] v_reg,
    output logic [63:0] res_reg
);

    localparam logic [63:0] BIT = 64'd1 << (2 * K);

    logic [63:0] sum;
    logic        ge;
    logic [63:0] v_next;
    logic [63:0] res_next;

    always_comb
    begin
        sum      = res_in + BIT;
        ge       = v_in >= sum;
        v_next   = ge ? (v_in - sum) : v_in;
        res_next = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

endmodule

// ----- hw/rtl/rmj_div_cell.sv -----
// One quotient bit of two restoring dividers that share a divisor.
// Depends on rmj_pkg for the quotient width.
module rmj_div_cell #(
    parameter int RW = 65,
    parameter int DW = 32,
    parameter int SH = 0
) (
    input  logic                  clk,
    input  logic [RW-1:0]         rem0_in,
    input  logic [RW-1:0]         rem1_in,
    input  logic [DW-1:0]         den_in,
    input  logic [rmj_pkg::QW-1:0] q0_in,
    input  logic [rmj_pkg::QW-1:0] q1_in,
    output logic [RW-1:0]         rem0_reg,
    output logic [RW-1:0]         rem1_reg,
    output logic [DW-1:0]         den_reg,
    output logic [rmj_pkg::QW-1:0] q0_reg,
    output logic [rmj_pkg::QW-1:0] q1_reg
);

    logic [RW-1:0]          trial;
    logic                   ge0;
    logic                   ge1;
    logic [RW-1:0]          rem0_next;
    logic [RW-1:0]          rem1_next;
    logic [rmj_pkg::QW-1:0] q0_next;
    logic [rmj_pkg::QW-1:0] q1_next;

    always_comb
    begin
        trial     = RW'(den_in) << SH;
        ge0       = rem0_in >= trial;
        ge1       = rem1_in >= trial;
        rem0_next = ge0 ? (rem0_in - trial) : rem0_in;
        rem1_next = ge1 ? (rem1_in - trial) : rem1_in;
        q0_next   = q0_in | (rmj_pkg::QW'(ge0) << SH);
        q1_next   = q1_in | (rmj_pkg::QW'(ge1) << SH);
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        den_reg  <= den_in;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
    end

endmodule

// ----- hw/rtl/radar_measurement_jacobian_top.sv -----
// Radar measurement Jacobian: one request per cycle sustained; busy stays
// low. The pipeline is the 32-cell square root chain and the 33-cell
// divider chains, plus 7 arithmetic stages.
// Results are never stalled. Reset (async, active low) empties the pipeline
// and sets the squared-distance floor to 7. Depends on rmj_pkg and the cells.
module radar_measurement_jacobian_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] range_by_px,
    output logic signed [31:0] range_by_py,
    output logic signed [31:0] bearing_by_px,
    output logic signed [31:0] bearing_by_py,
    output logic signed [31:0] rate_by_px,
    output logic signed [31:0] rate_by_py,
    output logic               floor_applied
);

    localparam int NSQ  = 32;
    localparam int NDIV = 33;
    localparam int LAT  = 72;
    // Remainder widths keep den << 32 and the shifted numerator in range.
    localparam int RW_A = (32 + FRAC_BITS > 65) ? 32 + FRAC_BITS : 65;
    localparam int RW_B = (32 + 2 * FRAC_BITS > 97) ? 32 + 2 * FRAC_BITS : 97;
    localparam int RW_C = (96 + FRAC_BITS > 129) ? 96 + FRAC_BITS : 129;
    localparam logic signed [31:0] UNIT = 32'(1 << FRAC_BITS);

    // Handshakes: always ready for a request and a config write.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Floor register.
    logic [16:0] floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= 17'd7;
        else if (cfg_valid && cfg_ready)
            floor_reg <= cfg_data;
    end

    // Stage 1: magnitudes and cross products.
    logic               vld1_reg;
    logic [31:0]        mx1_reg;
    logic [31:0]        my1_reg;
    logic               nx1_reg;
    logic               ny1_reg;
    logic signed [63:0] a1_reg;
    logic signed [63:0] b1_reg;

    // Stage 2: squares and cross magnitude.
    logic               vld2_reg;
    logic [63:0]        sqx2_reg;
    logic [63:0]        sqy2_reg;
    logic [31:0]        mx2_reg;
    logic [31:0]        my2_reg;
    logic               nx2_reg;
    logic               ny2_reg;
    logic [63:0]        cmag2_reg;
    logic               cneg2_reg;

    // Stage 3: sum of squares.
    logic               vld3_reg;
    logic [63:0]        s3_reg;
    logic [31:0]        mx3_reg;
    logic [31:0]        my3_reg;
    logic               nx3_reg;
    logic               ny3_reg;
    logic [63:0]        cmag3_reg;
    logic               cneg3_reg;

    // Stage 4: floored sum, the square root chain head.
    logic               vld4_reg;
    rmj_pkg::sqrt_tag_t tag4_reg;

    logic signed [64:0] diff;
    logic signed [64:0] diff_neg;
    logic [16:0]        floor_eff;
    logic [63:0]        floor_wide;

    always_comb
    begin
        diff       = 65'(a1_reg) - 65'(b1_reg);
        diff_neg   = -diff;
        floor_eff  = (floor_reg == 17'd0) ? 17'd1 : floor_reg;
        floor_wide = 64'(floor_eff) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx1_reg   <= pos_x[31] ? (~pos_x + 32'd1) : pos_x;
        my1_reg   <= pos_y[31] ? (~pos_y + 32'd1) : pos_y;
        nx1_reg   <= pos_x[31];
        ny1_reg   <= pos_y[31];
        a1_reg    <= 64'(vel_x) * 64'(pos_y);
        b1_reg    <= 64'(vel_y) * 64'(pos_x);

        sqx2_reg  <= 64'(mx1_reg) * 64'(mx1_reg);
        sqy2_reg  <= 64'(my1_reg) * 64'(my1_reg);
        mx2_reg   <= mx1_reg;
        my2_reg   <= my1_reg;
        nx2_reg   <= nx1_reg;
        ny2_reg   <= ny1_reg;
        cneg2_reg <= diff[64];
        cmag2_reg <= diff[64] ? diff_neg[63:0] : diff[63:0];

        s3_reg    <= sqx2_reg + sqy2_reg;
        mx3_reg   <= mx2_reg;
        my3_reg   <= my2_reg;
        nx3_reg   <= nx2_reg;
        ny3_reg   <= ny2_reg;
        cmag3_reg <= cmag2_reg;
        cneg3_reg <= cneg2_reg;

        // Raise a too-small squared distance to the floor.
        tag4_reg.sq   <= (s3_reg < floor_wide) ? floor_wide : s3_reg;
        tag4_reg.flag <= s3_reg < floor_wide;
        tag4_reg.mx   <= mx3_reg;
        tag4_reg.my   <= my3_reg;
        tag4_reg.nx   <= nx3_reg;
        tag4_reg.ny   <= ny3_reg;
        tag4_reg.cmag <= cmag3_reg;
        tag4_reg.cneg <= cneg3_reg;
    end

    // Square root chain: one result bit per cell, MSB first.
    logic [63:0]        sq_v [0:NSQ];
    logic [63:0]        sq_r [0:NSQ];
    rmj_pkg::sqrt_tag_t sq_tag_reg [0:NSQ-1];
    logic [NSQ-1:0]     sq_vld_reg;

    assign sq_v[0] = tag4_reg.sq;
    assign sq_r[0] = 64'd0;

    genvar i;
    generate
        for (i = 0; i < NSQ; i++)
        begin : g_sqrt
            rmj_sqrt_cell #(
                .K(NSQ - 1 - i)
            ) u_cell (
                .clk    (clk),
                .v_in   (sq_v[i]),
                .res_in (sq_r[i]),
                .v_reg  (sq_v[i + 1]),
                .res_reg(sq_r[i + 1])
            );

            if (i == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    sq_tag_reg[i] <= tag4_reg;
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        sq_vld_reg[i] <= 1'b0;
                    else
                        sq_vld_reg[i] <= vld4_reg;
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk)
                begin
                    sq_tag_reg[i] <= sq_tag_reg[i - 1];
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        sq_vld_reg[i] <= 1'b0;
                    else
                        sq_vld_reg[i] <= sq_vld_reg[i - 1];
                end
            end
        end
    endgenerate

    // Distance: the root of a 64-bit value fits in 32 bits.
    logic [31:0]        root_d;
    rmj_pkg::sqrt_tag_t tq;

    assign root_d = sq_r[NSQ][31:0];
    assign tq     = sq_tag_reg[NSQ - 1];

    // Stage P1: partial products of the 64 by 32 multiplies.
    logic          vp1_reg;
    logic [63:0]   sd_lo_reg;
    logic [63:0]   sd_hi_reg;
    logic [63:0]   my_lo_reg;
    logic [63:0]   my_hi_reg;
    logic [63:0]   mx_lo_reg;
    logic [63:0]   mx_hi_reg;
    logic [63:0]   s_p1_reg;
    logic [31:0]   d_p1_reg;
    logic [31:0]   mx_p1_reg;
    logic [31:0]   my_p1_reg;
    rmj_pkg::side_t side_p1_reg;

    // Stage P2: recombined products, the divider chain head.
    logic          vp2_reg;
    logic [95:0]   den3_reg;
    logic [95:0]   numy_reg;
    logic [95:0]   numx_reg;
    logic [63:0]   s_p2_reg;
    logic [31:0]   d_p2_reg;
    logic [31:0]   mx_p2_reg;
    logic [31:0]   my_p2_reg;
    rmj_pkg::side_t side_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
        end
        else
        begin
            vp1_reg <= sq_vld_reg[NSQ - 1];
            vp2_reg <= vp1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sd_lo_reg        <= 64'(tq.sq[31:0]) * 64'(root_d);
        sd_hi_reg        <= 64'(tq.sq[63:32]) * 64'(root_d);
        my_lo_reg        <= 64'(tq.my) * 64'(tq.cmag[31:0]);
        my_hi_reg        <= 64'(tq.my) * 64'(tq.cmag[63:32]);
        mx_lo_reg        <= 64'(tq.mx) * 64'(tq.cmag[31:0]);
        mx_hi_reg        <= 64'(tq.mx) * 64'(tq.cmag[63:32]);
        s_p1_reg         <= tq.sq;
        d_p1_reg         <= root_d;
        mx_p1_reg        <= tq.mx;
        my_p1_reg        <= tq.my;
        side_p1_reg.nx   <= tq.nx;
        side_p1_reg.ny   <= tq.ny;
        side_p1_reg.cneg <= tq.cneg;
        side_p1_reg.flag <= tq.flag;

        den3_reg    <= 96'(sd_lo_reg) + (96'(sd_hi_reg) << 32);
        numy_reg    <= 96'(my_lo_reg) + (96'(my_hi_reg) << 32);
        numx_reg    <= 96'(mx_lo_reg) + (96'(mx_hi_reg) << 32);
        s_p2_reg    <= s_p1_reg;
        d_p2_reg    <= d_p1_reg;
        mx_p2_reg   <= mx_p1_reg;
        my_p2_reg   <= my_p1_reg;
        side_p2_reg <= side_p1_reg;
    end

    // Divider chains: range over d, bearing over s, rate over s*d.
    logic [RW_A-1:0]        ra_x [0:NDIV];
    logic [RW_A-1:0]        ra_y [0:NDIV];
    logic [31:0]            da   [0:NDIV];
    logic [rmj_pkg::QW-1:0] qa_x [0:NDIV];
    logic [rmj_pkg::QW-1:0] qa_y [0:NDIV];
    logic [RW_B-1:0]        rb_y [0:NDIV];
    logic [RW_B-1:0]        rb_x [0:NDIV];
    logic [63:0]            db   [0:NDIV];
    logic [rmj_pkg::QW-1:0] qb_y [0:NDIV];
    logic [rmj_pkg::QW-1:0] qb_x [0:NDIV];
    logic [RW_C-1:0]        rc_y [0:NDIV];
    logic [RW_C-1:0]        rc_x [0:NDIV];
    logic [95:0]            dc   [0:NDIV];
    logic [rmj_pkg::QW-1:0] qc_y [0:NDIV];
    logic [rmj_pkg::QW-1:0] qc_x [0:NDIV];
    rmj_pkg::side_t         dv_side_reg [0:NDIV-1];
    logic [NDIV-1:0]        dv_vld_reg;

    assign ra_x[0] = RW_A'(mx_p2_reg) << FRAC_BITS;
    assign ra_y[0] = RW_A'(my_p2_reg) << FRAC_BITS;
    assign da[0]   = d_p2_reg;
    assign qa_x[0] = '0;
    assign qa_y[0] = '0;
    assign rb_y[0] = RW_B'(my_p2_reg) << (2 * FRAC_BITS);
    assign rb_x[0] = RW_B'(mx_p2_reg) << (2 * FRAC_BITS);
    assign db[0]   = s_p2_reg;
    assign qb_y[0] = '0;
    assign qb_x[0] = '0;
    assign rc_y[0] = RW_C'(numy_reg) << FRAC_BITS;
    assign rc_x[0] = RW_C'(numx_reg) << FRAC_BITS;
    assign dc[0]   = den3_reg;
    assign qc_y[0] = '0;
    assign qc_x[0] = '0;

    genvar j;
    generate
        for (j = 0; j < NDIV; j++)
        begin : g_div
            rmj_div_cell #(.RW(RW_A), .DW(32), .SH(NDIV - 1 - j)) u_range (
                .clk     (clk),
                .rem0_in (ra_x[j]),
                .rem1_in (ra_y[j]),
                .den_in  (da[j]),
                .q0_in   (qa_x[j]),
                .q1_in   (qa_y[j]),
                .rem0_reg(ra_x[j + 1]),
                .rem1_reg(ra_y[j + 1]),
                .den_reg (da[j + 1]),
                .q0_reg  (qa_x[j + 1]),
                .q1_reg  (qa_y[j + 1])
            );

            rmj_div_cell #(.RW(RW_B), .DW(64), .SH(NDIV - 1 - j)) u_bearing (
                .clk     (clk),
                .rem0_in (rb_y[j]),
                .rem1_in (rb_x[j]),
                .den_in  (db[j]),
                .q0_in   (qb_y[j]),
                .q1_in   (qb_x[j]),
                .rem0_reg(rb_y[j + 1]),
                .rem1_reg(rb_x[j + 1]),
                .den_reg (db[j + 1]),
                .q0_reg  (qb_y[j + 1]),
                .q1_reg  (qb_x[j + 1])
            );

            rmj_div_cell #(.RW(RW_C), .DW(96), .SH(NDIV - 1 - j)) u_rate (
                .clk     (clk),
                .rem0_in (rc_y[j]),
                .rem1_in (rc_x[j]),
                .den_in  (dc[j]),
                .q0_in   (qc_y[j]),
                .q1_in   (qc_x[j]),
                .rem0_reg(rc_y[j + 1]),
                .rem1_reg(rc_x[j + 1]),
                .den_reg (dc[j + 1]),
                .q0_reg  (qc_y[j + 1]),
                .q1_reg  (qc_x[j + 1])
            );

            if (j == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    dv_side_reg[j] <= side_p2_reg;
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        dv_vld_reg[j] <= 1'b0;
                    else
                        dv_vld_reg[j] <= vp2_reg;
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk)
                begin
                    dv_side_reg[j] <= dv_side_reg[j - 1];
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        dv_vld_reg[j] <= 1'b0;
                    else
                        dv_vld_reg[j] <= dv_vld_reg[j - 1];
                end
            end
        end
    endgenerate

    // Output stage: sign, saturate and strobe for one cycle.
    rmj_pkg::side_t     so;
    logic               done_reg;
    logic signed [31:0] rpx_reg;
    logic signed [31:0] rpy_reg;
    logic signed [31:0] bpx_reg;
    logic signed [31:0] bpy_reg;
    logic signed [31:0] tpx_reg;
    logic signed [31:0] tpy_reg;
    logic               flag_reg;

    assign so = dv_side_reg[NDIV - 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld_reg[NDIV - 1];
    end

    always_ff @(posedge clk)
    begin
        rpx_reg  <= $signed(rmj_pkg::sat_q(qa_x[NDIV], so.nx));
        rpy_reg  <= $signed(rmj_pkg::sat_q(qa_y[NDIV], so.ny));
        bpx_reg  <= $signed(rmj_pkg::sat_q(qb_y[NDIV], !so.ny));
        bpy_reg  <= $signed(rmj_pkg::sat_q(qb_x[NDIV], so.nx));
        tpx_reg  <= $signed(rmj_pkg::sat_q(qc_y[NDIV], so.ny != so.cneg));
        tpy_reg  <= $signed(rmj_pkg::sat_q(qc_x[NDIV], so.nx == so.cneg));
        flag_reg <= so.flag;
    end

    assign done          = done_reg;
    assign range_by_px   = rpx_reg;
    assign range_by_py   = rpy_reg;
    assign bearing_by_px = bpx_reg;
    assign bearing_by_py = bpy_reg;
    assign rate_by_px    = tpx_reg;
    assign rate_by_py    = tpy_reg;
    assign floor_applied = flag_reg;

`ifndef SYNTHESIS
    // Every accepted request comes out a fixed latency later.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing at fixed latency");

    // No result without a request that latency ago.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a request");

    // Distance never falls below a position component, so range entries
    // stay within plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (range_by_px <= UNIT) && (range_by_px >= -UNIT))
        else $error("range_by_px out of unit bound");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (range_by_py <= UNIT) && (range_by_py >= -UNIT))
        else $error("range_by_py out of unit bound");
`endif

endmodule

// ----- tb/sv/radar_measurement_jacobian_top_tb.sv -----
// Self-checking testbench for radar_measurement_jacobian_top: drives position and
// velocity requests, predicts the Jacobian entries and checks every result.
// Depends on the block's RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] rx, ry, bx, by, tx, ty;
    logic        flg;
} jac_t;

class jacobian_board;
    jac_t pending[$];
    int   errors;
    int   checked;
    logic [16:0] floor_val;

    function new();
        errors = 0;
        checked = 0;
        floor_val = 17'd7;
    endfunction

    // Clamp a magnitude, apply the sign, saturate to 32 bits.
    function logic [31:0] clamp_signed(logic [127:0] q, logic neg);
        logic [32:0] m;
        if (neg)
        begin
            m = (q > 128'h80000000) ? 33'h080000000 : q[32:0];
            return 32'(33'd0 - m);
        end
        m = (q > 128'h7FFFFFFF) ? 33'h07FFFFFFF : q[32:0];
        return m[31:0];
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if (({r[31:0] | (32'd1 << b)} * {r[31:0] | (32'd1 << b)}) <= {64'd0, v})
                r[b] = 1'b1;
        return r;
    endfunction

    function void note_request(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] vx, logic signed [31:0] vy);
        jac_t j;
        logic [63:0]  mx, my, s, d, fl;
        logic signed [127:0] a, b, c;
        logic [127:0] cm, den3;
        logic         nx, ny, cneg;
        nx = px[31];
        ny = py[31];
        mx = nx ? 64'(-64'(px)) : 64'(px);
        my = ny ? 64'(-64'(py)) : 64'(py);
        fl = 64'(floor_val == 0 ? 17'd1 : floor_val) << 16;
        s = mx * mx + my * my;
        j.flg = 1'b0;
        if (s < fl)
        begin
            s = fl;
            j.flg = 1'b1;
        end
        d = root_floor(s);
        a = 128'(vx) * 128'(py);
        b = 128'(vy) * 128'(px);
        c = a - b;
        cneg = c < 0;
        cm = cneg ? 128'(-c) : 128'(c);
        den3 = 128'(s) * 128'(d);
        j.rx = clamp_signed((128'(mx) << 16) / d, nx);
        j.ry = clamp_signed((128'(my) << 16) / d, ny);
        j.bx = clamp_signed((128'(my) << 32) / s, !ny);
        j.by = clamp_signed((128'(mx) << 32) / s, nx);
        // numerators stay under 2^112 so 128 bits hold them exactly
        j.tx = clamp_signed(((128'(my) * cm) << 16) / den3, ny != cneg);
        j.ty = clamp_signed(((128'(mx) * cm) << 16) / den3, nx == cneg);
        pending.push_back(j);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s exp %h got %h", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(jac_t got);
        jac_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: result with nothing expected", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        check_field("range_by_px", e.rx, got.rx);
        check_field("range_by_py", e.ry, got.ry);
        check_field("bearing_by_px", e.bx, got.bx);
        check_field("bearing_by_py", e.by, got.by);
        check_field("rate_by_px", e.tx, got.tx);
        check_field("rate_by_py", e.ty, got.ty);
        if (got.flg !== e.flg)
        begin
            $display("%0t: floor_applied exp %b got %b", $time, e.flg, got.flg);
            errors++;
        end
    endfunction
endclass

module radar_measurement_jacobian_top_tb;

    localparam int LATENCY = 72;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [16:0] cfg_data = '0;
    logic done;
    logic signed [31:0] range_by_px, range_by_py, bearing_by_px, bearing_by_py;
    logic signed [31:0] rate_by_px, rate_by_py;
    logic floor_applied;

    jacobian_board board = new();
    int idle_pct = 0;
    int requests = 0;
    int quiet_cycles = 0;
    int floor_hits = 0;

    always #4 clk = ~clk;

    radar_measurement_jacobian_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done),
        .range_by_px(range_by_px), .range_by_py(range_by_py),
        .bearing_by_px(bearing_by_px), .bearing_by_py(bearing_by_py),
        .rate_by_px(rate_by_px), .rate_by_py(rate_by_py),
        .floor_applied(floor_applied)
    );

    // Check each result in the cycle it is strobed; the block cannot be stalled.
    always @(posedge clk)
    begin
        jac_t got;
        if (rst_n && done)
        begin
            got.rx = range_by_px;
            got.ry = range_by_py;
            got.bx = bearing_by_px;
            got.by = bearing_by_py;
            got.tx = rate_by_px;
            got.ty = rate_by_py;
            got.flg = floor_applied;
            if (floor_applied === 1'b1)
                floor_hits++;
            board.check_result(got);
        end
    end

    // Watchdog: count cycles where no request, config write or result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("watchdog expired, %0d results outstanding", board.pending.size());
            $display("[radar_measurement_jacobian_top] ERROR");
            $finish;
        end
    end

    // Issue one request; hold start until it is taken, with random idle cycles first.
    task automatic send_state(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                              logic [31:0] vy);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        vel_x <= vx;
        vel_y <= vy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(px, py, vx, vy);
        requests++;
        @(negedge clk);
    endtask

    // Drain the pipeline, then let the latency pass before touching the register.
    task automatic drain_all();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_floor(logic [16:0] v);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.floor_val = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random value biased toward small magnitudes and the extremes.
    function automatic logic [31:0] pick_field();
        case ($urandom_range(9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'($signed($urandom_range(64)) - 32);
            3, 4: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
            5, 6: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++)
            send_state(pick_field(), pick_field(), pick_field(), pick_field());
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: origin hits the floor, extremes of every field, zero numerators.
        send_state(0, 0, 0, 0);
        send_state(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_state(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_state(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_state(32'h00010000, 0, 32'h00010000, 0);
        send_state(0, 32'hFFFF0000, 0, 32'h00020000);
        send_state(1, 1, 32'h7FFFFFFF, 32'h80000000);
        send_state(32'hFFFFFFFF, 0, 5, 7);
        send_state(2, 1, 32'h00030000, 32'hFFFD0000);
        send_state(32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
        send_state(32'hFFFD0000, 32'hFFFC0000, 32'hFFFF0000, 32'h00020000);
        send_state(32'h00000100, 32'h00000100, 32'h00010000, 32'h00010000);

        // Floor extremes: a large floor, then the zero value that acts as one.
        write_floor(17'h10000);
        send_state(32'h00008000, 32'hFFFF8000, 32'h00010000, 32'h7FFFFFFF);
        send_state(32'h00010000, 0, 1, 1);
        send_state(32'h00020000, 32'h00020000, 32'h80000000, 3);
        write_floor(17'd0);
        send_state(0, 0, 32'h12345678, 32'h9ABCDEF0);
        send_state(1, 0, 32'h00010000, 32'h00010000);
        write_floor(17'd1);
        send_state(0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);

        // Random phases across floor settings and idle rates.
        write_floor(17'd7);
        idle_pct = 0;
        random_burst(400);
        idle_pct = 46;
        random_burst(400);
        // Pause the sender until every result is back.
        drain_all();
        write_floor(17'h1FFFF);
        idle_pct = 28;
        random_burst(300);
        write_floor(17'd300);
        idle_pct = 0;
        random_burst(250);
        write_floor(17'd1);
        idle_pct = 46;
        random_burst(250);

        drain_all();
        $display("%0d requests, %0d results checked, %0d at the distance floor",
                 requests, board.checked, floor_hits);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[radar_measurement_jacobian_top] OK");
        else
            $display("[radar_measurement_jacobian_top] ERROR");
        $finish;
    end
endmodule
